// File: sv/icymd_pkg.sv
// Shared types, codes and constants for the ICY audio/metadata demultiplexer.
package icymd_pkg;

  localparam int DataBits      = 8;
  localparam int MetaintBits   = 24;
  localparam int CfgDataBits   = 24;
  localparam int CfgIdxBits    = 1;
  localparam int CounterBitsDefault = 24;

  localparam logic [DataBits-1:0] CrCode = 8'd13;
  localparam logic [DataBits-1:0] LfCode = 8'd10;

  // Configuration register indexes.
  localparam logic [CfgIdxBits-1:0] CFG_METADATA_ENABLE = 1'b0;
  localparam logic [CfgIdxBits-1:0] CFG_METAINT         = 1'b1;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_AUDIO  = 2'd1,
    KIND_LENGTH = 2'd2,
    KIND_META   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [DataBits-1:0] data_byte;
    logic                chunk_end;
  } in_item_t;

  typedef struct packed {
    logic [DataBits-1:0] out_byte;
    kind_e               byte_kind;
    logic                header_end;
    logic                chunk_end_out;
    logic                error;
  } out_item_t;

  typedef struct packed {
    logic                   metadata_enable;
    logic [MetaintBits-1:0] metaint;
  } cfg_t;

endpackage

// File: sv/icy_audio_metadata_demux_unit.sv
// Top level of the ICY demultiplexer: input register, state machine, result register.
// The block takes one stream byte per cycle when the output is not stalled and returns each
// byte with its label (header, audio, metadata length or metadata), a header-end flag,
// the chunk-end copy and a sticky error flag. Throughput is one item per cycle unless
// out_ready holds the result register; an item passes from the input register into the
// result register, with the stream state updated as it moves, and is presented from there.
// While a result waits, the input register can still take one more item.
// Configuration (index 0 metadata enable, index 1 metaint) is to be written by the user
// through the write port only while the block is idle; the block does not enforce this.
// Metaint is read each time an audio run is loaded.
module icy_audio_metadata_demux_unit import icymd_pkg::*; #(
  parameter int CounterBits = CounterBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  in_item_t               in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output out_item_t              out_item_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i
);

  cfg_t      cfg_q;
  in_item_t  in_item_q;
  logic      in_valid_q;
  out_item_t out_item_q;
  logic      out_valid_q;
  out_item_t result;
  logic      advance;
  logic      step;

  // The result register frees up when empty or when its item is taken.
  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_METADATA_ENABLE: cfg_q.metadata_enable <= cfg_wdata_i[0];
        CFG_METAINT:         cfg_q.metaint <= cfg_wdata_i[MetaintBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
    if (step) begin
      out_item_q <= result;
    end
  end

  icymd_core #(
    .CounterBits(CounterBits)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (in_item_q),
    .cfg_i   (cfg_q),
    .result_o(result)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: sv/icymd_core.sv
// Stream state machine: labels one byte per step and updates the run counter.
module icymd_core import icymd_pkg::*; #(
  parameter int CounterBits = CounterBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t result_o
);

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_AUDIO  = 4'b0010,
    PH_LENGTH = 4'b0100,
    PH_META   = 4'b1000
  } phase_e;

  localparam int WideBits = (CounterBits > MetaintBits) ? CounterBits : MetaintBits;
  localparam logic [2:0] HdrCountMax = 3'd7;
  localparam logic [2:0] HdrCountMin = 3'd4;
  localparam logic [3*DataBits-1:0] BlankTail = {CrCode, LfCode, CrCode};

  phase_e                  phase_q, phase_d;
  logic [CounterBits-1:0]  remaining_q, remaining_d;
  logic [3*DataBits-1:0]   recent_q, recent_d;
  logic [2:0]              hdr_count_q, hdr_count_d;
  logic                    failed_q, failed_d;

  logic [WideBits-1:0]     metaint_wide;
  logic [WideBits-1:0]     counter_max_wide;
  logic [CounterBits-1:0]  reload;
  logic [CounterBits-1:0]  meta_len;
  kind_e                   kind;
  logic                    hend;

  // A metaint beyond the counter range saturates the loaded run.
  assign metaint_wide     = WideBits'(cfg_i.metaint);
  assign counter_max_wide = WideBits'({CounterBits{1'b1}});
  assign reload = (metaint_wide > counter_max_wide) ? {CounterBits{1'b1}}
                                                    : CounterBits'(metaint_wide);
  assign meta_len = CounterBits'({item_i.data_byte, 4'h0});

  always_comb begin
    phase_d     = phase_q;
    remaining_d = remaining_q;
    recent_d    = recent_q;
    hdr_count_d = hdr_count_q;
    failed_d    = failed_q;
    kind        = KIND_AUDIO;
    hend        = 1'b0;
    if (!failed_q) begin
      case (phase_q)
        PH_HEADER: begin
          kind = KIND_HEADER;
          if (hdr_count_q >= HdrCountMin && recent_q == BlankTail &&
              item_i.data_byte == LfCode) begin
            hend        = 1'b1;
            phase_d     = PH_AUDIO;
            remaining_d = reload;
          end
          if (hdr_count_q != HdrCountMax) begin
            hdr_count_d = hdr_count_q + 3'd1;
          end
          recent_d = {recent_q[2*DataBits-1:0], item_i.data_byte};
        end
        PH_AUDIO: begin
          kind = KIND_AUDIO;
          if (cfg_i.metadata_enable) begin
            if (remaining_q == '0) begin
              failed_d = 1'b1;
            end else begin
              remaining_d = remaining_q - CounterBits'(1);
              if (remaining_q == CounterBits'(1)) begin
                phase_d = PH_LENGTH;
              end
            end
          end
        end
        PH_LENGTH: begin
          kind = KIND_LENGTH;
          if (item_i.data_byte == '0) begin
            phase_d     = PH_AUDIO;
            remaining_d = reload;
          end else begin
            phase_d     = PH_META;
            remaining_d = meta_len;
          end
        end
        PH_META: begin
          kind = KIND_META;
          // The last metadata byte (or an empty run) goes back to audio.
          if (remaining_q <= CounterBits'(1)) begin
            phase_d     = PH_AUDIO;
            remaining_d = reload;
          end else begin
            remaining_d = remaining_q - CounterBits'(1);
          end
        end
        default: begin
          phase_d = PH_HEADER;
        end
      endcase
    end
  end

  assign result_o.out_byte      = item_i.data_byte;
  assign result_o.byte_kind     = kind;
  assign result_o.header_end    = hend;
  assign result_o.chunk_end_out = item_i.chunk_end;
  assign result_o.error         = failed_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      remaining_q <= '0;
      recent_q    <= '0;
      hdr_count_q <= '0;
      failed_q    <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      remaining_q <= remaining_d;
      recent_q    <= recent_d;
      hdr_count_q <= hdr_count_d;
      failed_q    <= failed_d;
    end
  end

endmodule

// File: tb/sv/tb_icy_audio_metadata_demux_unit.sv
// Self-checking testbench for the ICY audio/metadata demultiplexer top level.
`timescale 1ns / 100ps

module tb_icy_audio_metadata_demux_unit;
  import icymd_pkg::*;

  localparam int CntBits = CounterBitsDefault;
  localparam longint unsigned CntMax = (64'd1 << CntBits) - 64'd1;
  localparam logic [23:0] BlankTail = {CrCode, LfCode, CrCode};
  localparam int IdlePct = 10;
  localparam int DrainCycles = 6;
  localparam int CycleLimit = 200000;
  localparam int MaxReports = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx = '0;
  logic [CfgDataBits-1:0] cfg_wdata = '0;

  // Model of the stream state and of the register copies.
  kind_e st_phase = KIND_HEADER;
  logic [CntBits-1:0] st_left = '0;
  logic [23:0] st_tail = '0;
  logic [2:0] st_hdr_cnt = '0;
  logic st_failed = 1'b0;
  logic m_enable = 1'b0;
  logic [MetaintBits-1:0] m_metaint = '0;

  out_item_t labeled_q[$];
  out_item_t want;
  bit no_gaps = 1'b0;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned kind_count[4] = '{0, 0, 0, 0};
  int unsigned cycle_count = 0;

  icy_audio_metadata_demux_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready <= no_gaps || ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Run stopped at cycle %0d with %0d results outstanding", cycle_count,
               labeled_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [CntBits-1:0] run_length();
    if (64'(m_metaint) > CntMax) begin
      return CntBits'(CntMax);
    end
    return CntBits'(m_metaint);
  endfunction

  function automatic bit ends_header(input logic [7:0] b);
    return !st_failed && st_phase == KIND_HEADER && st_hdr_cnt >= 3'd4 &&
           st_tail == BlankTail && b == LfCode;
  endfunction

  // Labels one byte and advances the model state.
  function automatic out_item_t label_byte(input logic [7:0] b, input logic ce);
    out_item_t r;
    r.out_byte = b;
    r.byte_kind = KIND_AUDIO;
    r.header_end = 1'b0;
    r.chunk_end_out = ce;
    if (!st_failed) begin
      case (st_phase)
        KIND_HEADER: begin
          r.byte_kind = KIND_HEADER;
          if (ends_header(b)) begin
            r.header_end = 1'b1;
            st_phase = KIND_AUDIO;
            st_left = run_length();
          end
          if (st_hdr_cnt < 3'd7) st_hdr_cnt = st_hdr_cnt + 3'd1;
          st_tail = {st_tail[15:0], b};
        end
        KIND_AUDIO: begin
          if (m_enable) begin
            if (st_left == '0) begin
              st_failed = 1'b1;
            end else begin
              st_left = st_left - 1'b1;
              if (st_left == '0) st_phase = KIND_LENGTH;
            end
          end
        end
        KIND_LENGTH: begin
          r.byte_kind = KIND_LENGTH;
          st_left = CntBits'({b, 4'b0000});
          if (st_left == '0) begin
            st_phase = KIND_AUDIO;
            st_left = run_length();
          end else begin
            st_phase = KIND_META;
          end
        end
        default: begin
          r.byte_kind = KIND_META;
          if (st_left != '0) st_left = st_left - 1'b1;
          if (st_left == '0) begin
            st_phase = KIND_AUDIO;
            st_left = run_length();
          end
        end
      endcase
    end
    r.error = st_failed;
    return r;
  endfunction

  // Length bytes stay small so that metadata blocks end quickly.
  function automatic logic [7:0] pick_byte();
    int unsigned roll;
    roll = $urandom_range(99);
    if (!st_failed && st_phase == KIND_LENGTH) begin
      if (roll < 30) return 8'd0;
      if (roll < 85) return 8'($urandom_range(2, 1));
      return 8'($urandom_range(5, 3));
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic logic pick_end();
    return $urandom_range(99) < 15;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t ns: %s expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Results are sampled at the falling edge, where the handshake signals are settled.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      results_seen++;
      kind_count[out_item.byte_kind]++;
      if (labeled_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t ns: unexpected item, expected none, actual %0h", $time, out_item);
      end else begin
        want = labeled_q.pop_front();
        check_field("out_byte", want.out_byte, out_item.out_byte);
        check_field("byte_kind", 8'(want.byte_kind), 8'(out_item.byte_kind));
        check_field("header_end", 8'(want.header_end), 8'(out_item.header_end));
        check_field("chunk_end_out", 8'(want.chunk_end_out), 8'(out_item.chunk_end_out));
        check_field("error", 8'(want.error), 8'(out_item.error));
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic ce);
    bit taken;
    if (!no_gaps && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < IdlePct);
    end
    in_valid <= 1'b1;
    in_item <= '{data_byte: b, chunk_end: ce};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = in_ready;
      @(posedge clk_i);
    end
    labeled_q.push_back(label_byte(b, ce));
    items_sent++;
  endtask

  task automatic send_random(input int n);
    repeat (n) send_byte(pick_byte(), pick_end());
  endtask

  task automatic send_until_phase(input kind_e k);
    int guard;
    guard = 0;
    while (!st_failed && st_phase != k && guard < 5000) begin
      send_byte(pick_byte(), pick_end());
      guard++;
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (labeled_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx,
                           input logic [CfgDataBits-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    if (idx == CFG_METADATA_ENABLE) m_enable = val[0];
    else m_metaint = val[MetaintBits-1:0];
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_reset();
    rst_ni <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
  endtask

  // Header bytes, an early blank line that is too short, noise, and the real end.
  task automatic test_header();
    int unsigned roll;
    logic [7:0] b;
    write_reg(CFG_METADATA_ENABLE, 24'd1);
    write_reg(CFG_METAINT, 24'd1);
    send_byte(CrCode, 1'b0);
    send_byte(LfCode, 1'b0);
    send_byte(CrCode, 1'b1);
    send_byte(LfCode, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    wait_idle();
    repeat (40) begin
      roll = $urandom_range(99);
      if (roll < 30) b = CrCode;
      else if (roll < 60) b = LfCode;
      else b = 8'($urandom_range(255));
      if (ends_header(b)) b = 8'h41;
      send_byte(b, pick_end());
    end
    send_byte(CrCode, 1'b0);
    send_byte(LfCode, 1'b0);
    send_byte(CrCode, 1'b0);
    send_byte(LfCode, 1'b1);
  endtask

  // Shortest audio run, an empty metadata block, then a one-unit block.
  task automatic test_short_runs();
    int i;
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    for (i = 0; i < 16; i++) send_byte((i % 2 == 0) ? 8'hFF : 8'h00, 1'(i == 15));
    send_byte(8'hA5, 1'b0);
  endtask

  // With metadata disabled the metadata block still completes; audio is not counted.
  task automatic test_enable_off();
    wait_idle();
    write_reg(CFG_METAINT, 24'd3);
    send_until_phase(KIND_LENGTH);
    send_byte(8'h01, 1'b0);
    wait_idle();
    write_reg(CFG_METADATA_ENABLE, 24'd0);
    send_random(30);
    wait_idle();
    write_reg(CFG_METADATA_ENABLE, 24'd1);
    send_random(10);
  endtask

  task automatic test_random_stream();
    int p;
    for (p = 0; p < 6; p++) begin
      wait_idle();
      write_reg(CFG_METADATA_ENABLE, (p == 2) ? 24'd0 : 24'd1);
      write_reg(CFG_METAINT, (p == 0) ? 24'd1 : 24'($urandom_range(12, 1)));
      no_gaps = (p == 3);
      send_random((p == 3) ? 60 : 20);
    end
    no_gaps = 1'b0;
  endtask

  // A length byte with two bits set gives a long metadata block.
  task automatic test_long_metadata();
    wait_idle();
    write_reg(CFG_METAINT, 24'd4);
    send_until_phase(KIND_LENGTH);
    send_byte(8'h09, 1'b1);
    while (!st_failed && st_phase == KIND_META) send_byte(pick_byte(), pick_end());
  endtask

  // A zero audio run with metadata on fails the stream for good.
  task automatic test_sticky_error();
    int guard;
    wait_idle();
    write_reg(CFG_METADATA_ENABLE, 24'd1);
    write_reg(CFG_METAINT, 24'd0);
    guard = 0;
    while (!st_failed && guard < 5000) begin
      send_byte(pick_byte(), pick_end());
      guard++;
    end
    send_random(20);
    wait_idle();
    write_reg(CFG_METAINT, 24'hFFFFFF);
    write_reg(CFG_METADATA_ENABLE, 24'd0);
    send_random(8);
    wait_idle();
    write_reg(CFG_METADATA_ENABLE, 24'd1);
    send_random(8);
    wait_idle();
  endtask

  initial begin
    apply_reset();
    test_header();
    test_short_runs();
    test_enable_off();
    test_random_stream();
    test_long_metadata();
    test_sticky_error();
    if (labeled_q.size() != 0) begin
      mismatches++;
      $display("%0t ns: expected %0d more items, actual 0", $time, labeled_q.size());
    end
    $display("Sent %0d bytes, checked %0d: %0d header, %0d audio, %0d length, %0d metadata.",
             items_sent, results_seen, kind_count[KIND_HEADER], kind_count[KIND_AUDIO],
             kind_count[KIND_LENGTH], kind_count[KIND_META]);
    $display("Covered header end, empty and long metadata blocks, enable off, sticky error.");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
